// ----- sv/prime_field_alu_defines.svh -----
// Assertion macros shared by the checking code of the prime field unit.
// Both sample on the rising edge of i_clk and are off while i_rst_n is low.
`ifndef PRIME_FIELD_ALU_DEFINES_SVH
`define PRIME_FIELD_ALU_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define PFA_CHECK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PFA_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/pfa_pkg.sv -----
`timescale 1ns / 1ps

package pfa_pkg;

    typedef logic [29:0] t_fe;
    typedef logic [2:0]  t_op;
    typedef logic [3:0]  t_pc;
    typedef logic [2:0]  t_uop;
    typedef logic [1:0]  t_cond;
    typedef logic        t_dst;

    localparam t_fe          P_MOD    = 30'd998244353;
    localparam logic [31:0]  BARRETT_MU = 32'd2309898375; // floor(2^61 / P_MOD)
    localparam t_fe          R_2P30   = 30'd75497471;     // 2^30 mod P_MOD
    localparam logic [62:0]  E_INV    = 63'd998244351;    // P_MOD - 2

    localparam t_op OP_RED = 3'd0;
    localparam t_op OP_ADD = 3'd1;
    localparam t_op OP_SUB = 3'd2;
    localparam t_op OP_MUL = 3'd3;
    localparam t_op OP_DIV = 3'd4;
    localparam t_op OP_POW = 3'd5;
    localparam t_op OP_INV = 3'd6;
    localparam t_op OP_NEG = 3'd7;

    localparam t_uop U_NOP          = 3'd0;
    localparam t_uop U_MUL_ACC_A    = 3'd1;
    localparam t_uop U_MUL_ACC_BASE = 3'd2;
    localparam t_uop U_SQR_BASE     = 3'd3;
    localparam t_uop U_HORNER       = 3'd4;
    localparam t_uop U_WAIT         = 3'd5;
    localparam t_uop U_WAIT_SHIFT   = 3'd6;
    localparam t_uop U_OUT          = 3'd7;

    localparam t_cond C_NEVER = 2'd0;
    localparam t_cond C_EZERO = 2'd1;
    localparam t_cond C_EMORE = 2'd2;
    localparam t_cond C_DIV   = 2'd3;

    localparam t_dst DST_ACC  = 1'b0;
    localparam t_dst DST_BASE = 1'b1;

    // program entry points and jump targets
    localparam t_pc PC_ALU   = 4'd0;
    localparam t_pc PC_MUL   = 4'd1;
    localparam t_pc PC_EXP   = 4'd4;
    localparam t_pc PC_LOOP  = 4'd5;
    localparam t_pc PC_EXIT  = 4'd8;
    localparam t_pc PC_RED   = 4'd10;

    typedef struct packed {
        t_uop  uop;
        t_cond cond;
        t_pc   target;
    } t_uword;

    typedef struct packed {
        logic run;
        logic fire;
        t_uop uop;
    } t_seq_ctrl;

    typedef struct packed {
        logic busy;
        logic out_full;
        logic e_zero;
        logic e_more;
        logic is_div;
    } t_seq_stat;

    typedef struct packed {
        logic valid;
        t_dst dst;
        t_fe  x;
        t_fe  y;
        t_fe  c;
    } t_mul_req;

    typedef struct packed {
        logic valid;
        t_dst dst;
        t_fe  value;
    } t_mul_wb;

    function automatic t_fe fold30(input t_fe v);
        return (v >= P_MOD) ? v - P_MOD : v;
    endfunction

    function automatic t_fe fneg(input t_fe a);
        return (a != '0) ? P_MOD - a : '0;
    endfunction

    function automatic t_fe fadd(input t_fe a, input t_fe b);
        logic [30:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, P_MOD}) begin
            s = s - {1'b0, P_MOD};
        end
        return s[29:0];
    endfunction

    function automatic t_fe fsub(input t_fe a, input t_fe b);
        // wraps mod 2^30, exact since the true result is below P_MOD
        return (a >= b) ? a - b : a + P_MOD - b;
    endfunction

    function automatic t_uword uw(input t_uop u, input t_cond c, input t_pc t);
        t_uword w;
        w.uop    = u;
        w.cond   = c;
        w.target = t;
        return w;
    endfunction

    function automatic t_uword rom(input t_pc pc);
        case (pc)
            4'd0:    return uw(U_OUT,          C_NEVER, PC_ALU);
            4'd1:    return uw(U_MUL_ACC_A,    C_NEVER, PC_ALU);
            4'd2:    return uw(U_WAIT,         C_NEVER, PC_ALU);
            4'd3:    return uw(U_OUT,          C_NEVER, PC_ALU);
            4'd4:    return uw(U_NOP,          C_EZERO, PC_EXIT);
            4'd5:    return uw(U_MUL_ACC_BASE, C_NEVER, PC_ALU);
            4'd6:    return uw(U_SQR_BASE,     C_NEVER, PC_ALU);
            4'd7:    return uw(U_WAIT_SHIFT,   C_EMORE, PC_LOOP);
            4'd8:    return uw(U_NOP,          C_DIV,   PC_MUL);
            4'd9:    return uw(U_OUT,          C_NEVER, PC_ALU);
            4'd10:   return uw(U_HORNER,       C_NEVER, PC_ALU);
            4'd11:   return uw(U_WAIT,         C_NEVER, PC_ALU);
            4'd12:   return uw(U_HORNER,       C_NEVER, PC_ALU);
            4'd13:   return uw(U_WAIT,         C_NEVER, PC_ALU);
            4'd14:   return uw(U_OUT,          C_NEVER, PC_ALU);
            default: return uw(U_OUT,          C_NEVER, PC_ALU);
        endcase
    endfunction

    function automatic t_pc entry(input t_op op);
        case (op)
            OP_RED:  return PC_RED;
            OP_MUL:  return PC_MUL;
            OP_DIV:  return PC_EXP;
            OP_POW:  return PC_EXP;
            OP_INV:  return PC_EXP;
            default: return PC_ALU;
        endcase
    endfunction

endpackage

// ----- sv/pfa_req_if.sv -----
`timescale 1ns / 1ps

interface pfa_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         operation;
    logic [29:0]        left;
    logic [29:0]        right;
    logic [62:0]        exponent;
    logic signed [63:0] raw_value;

    modport source (output valid, operation, left, right, exponent, raw_value,
                    input ready);
    modport sink   (input valid, operation, left, right, exponent, raw_value,
                    output ready);
endinterface

// ----- sv/pfa_rsp_if.sv -----
`timescale 1ns / 1ps

interface pfa_rsp_if;
    logic        valid;
    logic        ready;
    logic [29:0] result;

    modport source (output valid, result, input ready);
    modport sink   (input valid, result, output ready);
endinterface

// ----- sv/pfa_mulmod.sv -----
`timescale 1ns / 1ps

// (x * y + c) mod P, Barrett reduction; product, quotient and remainder are registered in turn (r_p, r_q, r_r)
module pfa_mulmod (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pfa_pkg::t_mul_req i_req,
    output pfa_pkg::t_mul_wb  o_wb,
    output logic              o_busy
);

    logic              r_v1, r_v2, r_v3;
    pfa_pkg::t_dst     r_d1, r_d2, r_d3;
    logic [60:0]       r_p;
    logic [31:0]       r_q;
    logic [31:0]       r_plo;
    logic [31:0]       r_r;

    logic [59:0]       w_prod;
    logic [60:0]       n_p;
    logic [63:0]       w_t;
    logic [31:0]       w_qp;
    logic [31:0]       w_r1;
    logic [31:0]       w_r2;

    assign w_prod = {30'd0, i_req.x} * {30'd0, i_req.y};
    assign n_p    = {1'b0, w_prod} + {31'd0, i_req.c};
    assign w_t    = {32'd0, r_p[60:29]} * {32'd0, pfa_pkg::BARRETT_MU};
    // only the low word of q * P matters: the remainder is below 3P < 2^32
    assign w_qp   = r_q * {2'd0, pfa_pkg::P_MOD};

    always_comb begin
        w_r1 = (r_r >= {2'd0, pfa_pkg::P_MOD}) ? r_r - {2'd0, pfa_pkg::P_MOD} : r_r;
        w_r2 = (w_r1 >= {2'd0, pfa_pkg::P_MOD}) ? w_r1 - {2'd0, pfa_pkg::P_MOD} : w_r1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_req.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d1  <= i_req.dst;
        r_p   <= n_p;
        r_d2  <= r_d1;
        r_q   <= w_t[63:32];
        r_plo <= r_p[31:0];
        r_d3  <= r_d2;
        r_r   <= r_plo - w_qp;
    end

    assign o_wb.valid = r_v3;
    assign o_wb.dst   = r_d3;
    assign o_wb.value = w_r2[29:0];
    assign o_busy     = r_v1 | r_v2 | r_v3;

endmodule

// ----- sv/pfa_seq.sv -----
`timescale 1ns / 1ps

// step counter over the control store, one control word per step
module pfa_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  pfa_pkg::t_op       i_op,
    input  pfa_pkg::t_seq_stat i_stat,
    output pfa_pkg::t_seq_ctrl o_ctrl
);

    pfa_pkg::t_pc    r_pc, n_pc;
    logic            r_run, n_run;
    pfa_pkg::t_uword w_word;
    logic            w_stall;
    logic            w_jump;
    logic            w_fire;

    assign w_word = pfa_pkg::rom(r_pc);

    always_comb begin
        case (w_word.uop)
            pfa_pkg::U_WAIT:       w_stall = i_stat.busy;
            pfa_pkg::U_WAIT_SHIFT: w_stall = i_stat.busy;
            pfa_pkg::U_OUT:        w_stall = i_stat.out_full;
            default:               w_stall = 1'b0;
        endcase
    end

    always_comb begin
        case (w_word.cond)
            pfa_pkg::C_EZERO: w_jump = i_stat.e_zero;
            pfa_pkg::C_EMORE: w_jump = i_stat.e_more;
            pfa_pkg::C_DIV:   w_jump = i_stat.is_div;
            default:          w_jump = 1'b0;
        endcase
    end

    assign w_fire = r_run & ~w_stall;

    always_comb begin
        n_pc  = r_pc;
        n_run = r_run;
        if (i_start) begin
            n_pc  = pfa_pkg::entry(i_op);
            n_run = 1'b1;
        end else if (w_fire) begin
            if (w_word.uop == pfa_pkg::U_OUT) begin
                n_run = 1'b0;
            end else if (w_jump) begin
                n_pc = w_word.target;
            end else begin
                n_pc = r_pc + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= pfa_pkg::PC_ALU;
            r_run <= 1'b0;
        end else begin
            r_pc  <= n_pc;
            r_run <= n_run;
        end
    end

    assign o_ctrl.run  = r_run;
    assign o_ctrl.fire = w_fire;
    assign o_ctrl.uop  = w_word.uop;

endmodule

// ----- sv/prime_field_alu.sv -----
`timescale 1ns / 1ps
// channel  dir  type        fields
// i_req    in   pfa_req_if  operation, left, right, exponent, raw_value
// o_rsp    out  pfa_rsp_if  result
//
// add, sub, negate: formed at the output step; multiply: one product.
// power: square-and-multiply over exponent bits up to its top set bit,
// waiting on the multiplier writeback; inverse: power by P - 2; divide:
// left times inverse of right; reduce: two Horner steps, negated if below 0.
// Synchronous reset clears sequencer, multiplier valids and the output stage.
// A new request is taken while a result still waits; a stalled result holds
// the sequencer at its output step.
`include "prime_field_alu_defines.svh"

module prime_field_alu (
    input  logic           i_clk,
    input  logic           i_rst_n,
    pfa_req_if.sink        i_req,
    pfa_rsp_if.source      o_rsp
);

    pfa_pkg::t_seq_ctrl w_ctrl;
    pfa_pkg::t_seq_stat w_stat;
    pfa_pkg::t_mul_req  w_mreq;
    pfa_pkg::t_mul_wb   w_wb;
    logic               w_busy;
    logic               w_start;

    pfa_pkg::t_op       r_op;
    pfa_pkg::t_fe       r_a, r_b, r_acc, r_base, r_out_result;
    logic [62:0]        r_e;
    logic [59:0]        r_mag;
    logic               r_neg;
    logic               r_out_valid;

    pfa_pkg::t_fe       n_a, n_b, n_out;
    logic [63:0]        n_mag;

    assign i_req.ready = ~w_ctrl.run;
    assign w_start     = i_req.valid & i_req.ready;

    assign n_a   = pfa_pkg::fold30(i_req.left);
    assign n_b   = pfa_pkg::fold30(i_req.right);
    assign n_mag = i_req.raw_value[63] ? 64'(-i_req.raw_value) : 64'(i_req.raw_value);

    assign w_stat.busy     = w_busy;
    assign w_stat.out_full = r_out_valid & ~o_rsp.ready;
    assign w_stat.e_zero   = (r_e == '0);
    assign w_stat.e_more   = (r_e[62:1] != '0);
    assign w_stat.is_div   = (r_op == pfa_pkg::OP_DIV);

    pfa_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_op    (i_req.operation),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    always_comb begin
        w_mreq.valid = 1'b0;
        w_mreq.dst   = pfa_pkg::DST_ACC;
        w_mreq.x     = r_acc;
        w_mreq.y     = r_base;
        w_mreq.c     = '0;
        if (w_ctrl.fire) begin
            case (w_ctrl.uop)
                pfa_pkg::U_MUL_ACC_A: begin
                    w_mreq.valid = 1'b1;
                    w_mreq.y     = r_a;
                end
                pfa_pkg::U_MUL_ACC_BASE: begin
                    w_mreq.valid = r_e[0];
                end
                pfa_pkg::U_SQR_BASE: begin
                    w_mreq.valid = 1'b1;
                    w_mreq.dst   = pfa_pkg::DST_BASE;
                    w_mreq.x     = r_base;
                end
                pfa_pkg::U_HORNER: begin
                    // acc = acc * 2^30 + next 30-bit chunk of the magnitude
                    w_mreq.valid = 1'b1;
                    w_mreq.y     = pfa_pkg::R_2P30;
                    w_mreq.c     = r_mag[59:30];
                end
                default: begin
                    w_mreq.valid = 1'b0;
                end
            endcase
        end
    end

    pfa_mulmod u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mreq),
        .o_wb    (w_wb),
        .o_busy  (w_busy)
    );

    always_comb begin
        case (r_op)
            pfa_pkg::OP_ADD: n_out = pfa_pkg::fadd(r_a, r_b);
            pfa_pkg::OP_SUB: n_out = pfa_pkg::fsub(r_a, r_b);
            pfa_pkg::OP_NEG: n_out = pfa_pkg::fneg(r_a);
            pfa_pkg::OP_RED: n_out = r_neg ? pfa_pkg::fneg(r_acc) : r_acc;
            default:         n_out = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_op   <= i_req.operation;
            r_a    <= n_a;
            r_b    <= n_b;
            r_e    <= (i_req.operation == pfa_pkg::OP_POW) ? i_req.exponent
                                                           : pfa_pkg::E_INV;
            r_base <= (i_req.operation == pfa_pkg::OP_DIV) ? n_b : n_a;
            r_mag  <= n_mag[59:0];
            r_neg  <= i_req.raw_value[63];
            case (i_req.operation)
                pfa_pkg::OP_MUL: r_acc <= n_b;
                pfa_pkg::OP_RED: r_acc <= {26'd0, n_mag[63:60]};
                default:         r_acc <= 30'd1;
            endcase
        end else begin
            if (w_wb.valid) begin
                if (w_wb.dst == pfa_pkg::DST_BASE) begin
                    r_base <= w_wb.value;
                end else begin
                    r_acc <= w_wb.value;
                end
            end
            if (w_ctrl.fire && w_ctrl.uop == pfa_pkg::U_WAIT_SHIFT) begin
                r_e <= {1'b0, r_e[62:1]};
            end
            if (w_ctrl.fire && w_ctrl.uop == pfa_pkg::U_HORNER) begin
                r_mag <= {r_mag[29:0], 30'd0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.fire && w_ctrl.uop == pfa_pkg::U_OUT) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.fire && w_ctrl.uop == pfa_pkg::U_OUT) begin
            r_out_result <= n_out;
        end
    end

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.result = r_out_result;

    `PFA_CHECK_NOW(a_result_in_field, o_rsp.valid, o_rsp.result < pfa_pkg::P_MOD, "result out of field")
    `PFA_CHECK_NEXT(a_one_at_a_time, w_start, !i_req.ready, "request taken while busy")
    `PFA_CHECK_NOW(a_wb_while_run, w_wb.valid, w_ctrl.run, "writeback with sequencer idle")

endmodule
